// ===== src/scba_pkg.sv =====
// shared types and constants for the size class bump allocator
`default_nettype none

package scba_pkg;

  localparam int POOL_SLOTS      = 3;
  localparam int NUM_POOLS_DEF   = 3;
  localparam int CHUNKS_DEF      = 1024;

  localparam int SHIFT_W   = 5;
  localparam int ADDR_W    = 32;
  localparam int BYTES_W   = 16;
  localparam int IDX_W     = 2;
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 40;

  // operation codes carried on s_tuser
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // register indexes, byte address is 4 * index
  localparam logic [REG_IDX_W-1:0] REG_SIZE_SHIFT_0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_SHIFT_1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_SHIFT_2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_POOL_BASE_0  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_POOL_BASE_1  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_POOL_BASE_2  = 3'd5;

  localparam logic [SHIFT_W-1:0] SIZE_SHIFT_0_RST = 5'd5;
  localparam logic [SHIFT_W-1:0] SIZE_SHIFT_1_RST = 5'd6;
  localparam logic [SHIFT_W-1:0] SIZE_SHIFT_2_RST = 5'd7;

  typedef logic [SHIFT_W-1:0] shift_t;
  typedef logic [ADDR_W-1:0]  addr_t;

  // per pool verdict for the item in the work stage
  typedef struct packed {
    logic  can_alloc;
    logic  owns;
    addr_t grant_addr;
  } pool_status_t;

endpackage

`default_nettype wire

// ===== src/size_class_bump_allocator_top.sv =====
// top level: apb registers, input stage, per pool checks, counters, result register
// a beat passes the input register, then the result register, before it shows on m_tdata
// throughput: one beat per cycle unless m_tready stalls; counters update with the decision
// the counter read-modify-write sits between the input register and the result register
// reset (rst, synchronous): pool counters cleared, shifts 5/6/7, bases 0, both stages empty
// no clearing pass, the block takes beats from the first cycle after reset
`default_nettype none

module size_class_bump_allocator_top #(
  parameter int NUM_POOLS       = scba_pkg::NUM_POOLS_DEF,
  parameter int CHUNKS_PER_POOL = scba_pkg::CHUNKS_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  // apb register port
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire  [scba_pkg::PADDR_W-1:0]      paddr,
  input  wire  [scba_pkg::PDATA_W-1:0]      pwdata,
  output logic [scba_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  // request stream
  input  wire                               s_tvalid,
  output logic                              s_tready,
  // request_bytes [15:0], release_address [47:16]
  input  wire  [scba_pkg::S_TDATA_W-1:0]    s_tdata,
  // operation [0]
  input  wire                               s_tuser,
  // result stream
  output logic                              m_tvalid,
  input  wire                               m_tready,
  // granted_address [31:0], from_pool [32], pool_index [34:33], zero [39:35]
  output logic [scba_pkg::M_TDATA_W-1:0]    m_tdata
);
  import scba_pkg::*;

  // registers exist for three pools only
  localparam int ACTIVE_POOLS = (NUM_POOLS < POOL_SLOTS) ? NUM_POOLS : POOL_SLOTS;
  localparam int CNT_W        = $clog2(CHUNKS_PER_POOL + 1);

  shift_t size_shift [POOL_SLOTS];
  addr_t  pool_base  [POOL_SLOTS];

  scba_csr u_csr (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .size_shift (size_shift),
    .pool_base  (pool_base)
  );

  // input stage
  logic               in_valid;
  logic               in_op;
  logic [BYTES_W-1:0] in_bytes;
  addr_t              in_addr;

  // result stage
  logic               out_valid;
  addr_t              out_grant;
  logic               out_from_pool;
  logic [IDX_W-1:0]   out_index;

  logic advance;

  // the work stage moves whenever the result register is free or being drained
  assign advance  = ~out_valid | m_tready;
  assign s_tready = ~in_valid | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid & s_tready) begin
      in_op    <= s_tuser;
      in_bytes <= s_tdata[BYTES_W-1:0];
      in_addr  <= s_tdata[BYTES_W +: ADDR_W];
    end
  end

  // per pool checks against the live counters
  logic [CNT_W-1:0] chunks_used [ACTIVE_POOLS];
  pool_status_t     pool_st     [ACTIVE_POOLS];

  for (genvar g = 0; g < ACTIVE_POOLS; g++) begin : g_pool
    scba_pool #(
      .CHUNKS_PER_POOL (CHUNKS_PER_POOL),
      .CNT_W           (CNT_W)
    ) u_pool (
      .size_shift      (size_shift[g]),
      .pool_base       (pool_base[g]),
      .used            (chunks_used[g]),
      .request_bytes   (in_bytes),
      .release_address (in_addr),
      .status          (pool_st[g])
    );
  end

  // lowest index wins for both allocate and release
  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  addr_t             hit_grant;
  logic [ACTIVE_POOLS-1:0] bump;

  always_comb begin
    hit       = 1'b0;
    hit_idx   = '0;
    hit_grant = '0;
    bump      = '0;
    for (int i = 0; i < ACTIVE_POOLS; i++) begin
      if (!hit) begin
        if (in_op == OP_ALLOC && pool_st[i].can_alloc) begin
          hit       = 1'b1;
          hit_idx   = IDX_W'(i);
          hit_grant = pool_st[i].grant_addr;
          bump[i]   = 1'b1;
        end else if (in_op == OP_RELEASE && pool_st[i].owns) begin
          hit     = 1'b1;
          hit_idx = IDX_W'(i);
        end
      end
    end
  end

  // bump counters only when the item really leaves the work stage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ACTIVE_POOLS; i++) begin
        chunks_used[i] <= '0;
      end
    end else if (in_valid & advance) begin
      for (int i = 0; i < ACTIVE_POOLS; i++) begin
        if (bump[i]) begin
          chunks_used[i] <= chunks_used[i] + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid & advance) begin
      out_grant     <= hit_grant;
      out_from_pool <= hit;
      out_index     <= hit_idx;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W - ADDR_W - 1 - IDX_W)'(0), out_index, out_from_pool, out_grant};

endmodule

`default_nettype wire

// ===== src/scba_csr.sv =====
// apb register file holding pool chunk shifts and base addresses
`default_nettype none

module scba_csr (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [scba_pkg::PADDR_W-1:0]     paddr,
  input  wire  [scba_pkg::PDATA_W-1:0]     pwdata,
  output logic [scba_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready,
  output scba_pkg::shift_t                 size_shift [scba_pkg::POOL_SLOTS],
  output scba_pkg::addr_t                  pool_base  [scba_pkg::POOL_SLOTS]
);
  import scba_pkg::*;

  logic                 wr_en;
  logic [REG_IDX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      size_shift[0] <= SIZE_SHIFT_0_RST;
      size_shift[1] <= SIZE_SHIFT_1_RST;
      size_shift[2] <= SIZE_SHIFT_2_RST;
      pool_base[0]  <= '0;
      pool_base[1]  <= '0;
      pool_base[2]  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_SIZE_SHIFT_0: size_shift[0] <= pwdata[SHIFT_W-1:0];
        REG_SIZE_SHIFT_1: size_shift[1] <= pwdata[SHIFT_W-1:0];
        REG_SIZE_SHIFT_2: size_shift[2] <= pwdata[SHIFT_W-1:0];
        REG_POOL_BASE_0:  pool_base[0]  <= pwdata[ADDR_W-1:0];
        REG_POOL_BASE_1:  pool_base[1]  <= pwdata[ADDR_W-1:0];
        REG_POOL_BASE_2:  pool_base[2]  <= pwdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_SIZE_SHIFT_0: prdata = PDATA_W'(size_shift[0]);
      REG_SIZE_SHIFT_1: prdata = PDATA_W'(size_shift[1]);
      REG_SIZE_SHIFT_2: prdata = PDATA_W'(size_shift[2]);
      REG_POOL_BASE_0:  prdata = PDATA_W'(pool_base[0]);
      REG_POOL_BASE_1:  prdata = PDATA_W'(pool_base[1]);
      REG_POOL_BASE_2:  prdata = PDATA_W'(pool_base[2]);
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/scba_pool.sv =====
// one pool: fit check, bump address and range ownership check
`default_nettype none

module scba_pool #(
  parameter int CHUNKS_PER_POOL = scba_pkg::CHUNKS_DEF,
  parameter int CNT_W           = $clog2(CHUNKS_PER_POOL + 1)
) (
  input  scba_pkg::shift_t                 size_shift,
  input  scba_pkg::addr_t                  pool_base,
  input  wire  [CNT_W-1:0]                 used,
  input  wire  [scba_pkg::BYTES_W-1:0]     request_bytes,
  input  scba_pkg::addr_t                  release_address,
  output scba_pkg::pool_status_t           status
);
  import scba_pkg::*;

  localparam logic [CNT_W-1:0]  CNT_LIM = CNT_W'(CHUNKS_PER_POOL);
  localparam logic [ADDR_W:0]   OFS_LIM = (ADDR_W+1)'(CHUNKS_PER_POOL);

  logic  fits;
  logic  has_free;
  addr_t offset;
  logic  above_base;
  addr_t rel_ofs;

  // request fits when nothing survives shifting out the chunk size bits
  assign fits     = ((request_bytes >> size_shift) == '0);
  assign has_free = (used < CNT_LIM);
  assign offset   = ADDR_W'(used) << size_shift;

  // in range when the address is at or above the base and the chunk number of the offset is below the pool depth
  assign above_base = (release_address >= pool_base);
  assign rel_ofs    = release_address - pool_base;

  assign status.can_alloc  = fits & has_free;
  assign status.grant_addr = pool_base + offset;
  assign status.owns       = above_base & ({1'b0, rel_ofs >> size_shift} < OFS_LIM);

endmodule

`default_nettype wire
